>>> design/rdga_pkg.sv
// shared constants and types for the gray axis distance pipeline
`timescale 1ns / 1ps

package rdga_pkg;

    // channel sample width and result width
    localparam int CHAN_W = 8;
    localparam int DIST_W = 8;

    // radicand 24*s fits 21 bits, padded to an even 22 for two bits per cell
    localparam int RAD_W  = 22;
    // one root bit per cell
    localparam int ROOT_W = RAD_W / 2;
    localparam int NUM_CELLS = ROOT_W;
    // partial remainder never exceeds twice the partial root
    localparam int REM_W  = ROOT_W + 1;

    // reciprocal of six scaled by 2^RECIP_SH, exact for roots below 2^11
    localparam int RECIP_SH = 18;
    localparam logic [15:0] RECIP_SIX = 16'd43691;
    localparam logic [ROOT_W-1:0] ROUND_BIAS = ROOT_W'(3);

    // data handed from one square root cell to the next
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } cell_t;

endpackage

>>> design/rdga_front.sv
// front stages: channel differences, squares and scaled radicand 24*s
`timescale 1ns / 1ps

module rdga_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [rdga_pkg::CHAN_W-1:0]   red,
    input  logic [rdga_pkg::CHAN_W-1:0]   green,
    input  logic [rdga_pkg::CHAN_W-1:0]   blue,
    output logic                          front_valid,
    output rdga_pkg::cell_t               front_data
);

    logic signed [rdga_pkg::CHAN_W:0]       diff_rg;
    logic signed [rdga_pkg::CHAN_W:0]       diff_gb;
    logic signed [rdga_pkg::CHAN_W:0]       diff_br;
    logic signed [2*rdga_pkg::CHAN_W+1:0]   prod_rg;
    logic signed [2*rdga_pkg::CHAN_W+1:0]   prod_gb;
    logic signed [2*rdga_pkg::CHAN_W+1:0]   prod_br;
    logic [2*rdga_pkg::CHAN_W-1:0]          sq_rg_reg, sq_rg_next;
    logic [2*rdga_pkg::CHAN_W-1:0]          sq_gb_reg, sq_gb_next;
    logic [2*rdga_pkg::CHAN_W-1:0]          sq_br_reg, sq_br_next;
    logic                                   sq_valid_reg;
    logic [2*rdga_pkg::CHAN_W:0]            sq_sum;
    logic [2*rdga_pkg::CHAN_W-1:0]          s_val;
    logic [rdga_pkg::RAD_W-1:0]             rad_next;
    logic [rdga_pkg::RAD_W-1:0]             rad_reg;
    logic                                   rad_valid_reg;

    // squared pairwise differences, each at most 255^2
    always_comb
    begin
        diff_rg = $signed({1'b0, red})   - $signed({1'b0, green});
        diff_gb = $signed({1'b0, green}) - $signed({1'b0, blue});
        diff_br = $signed({1'b0, blue})  - $signed({1'b0, red});
        prod_rg = (2*rdga_pkg::CHAN_W+2)'(diff_rg) * (2*rdga_pkg::CHAN_W+2)'(diff_rg);
        prod_gb = (2*rdga_pkg::CHAN_W+2)'(diff_gb) * (2*rdga_pkg::CHAN_W+2)'(diff_gb);
        prod_br = (2*rdga_pkg::CHAN_W+2)'(diff_br) * (2*rdga_pkg::CHAN_W+2)'(diff_br);
        sq_rg_next = prod_rg[2*rdga_pkg::CHAN_W-1:0];
        sq_gb_next = prod_gb[2*rdga_pkg::CHAN_W-1:0];
        sq_br_next = prod_br[2*rdga_pkg::CHAN_W-1:0];
    end

    // s is half the sum of squares, then 24*s = 16*s + 8*s
    always_comb
    begin
        sq_sum = {1'b0, sq_rg_reg} + {1'b0, sq_gb_reg} + {1'b0, sq_br_reg};
        s_val = sq_sum[2*rdga_pkg::CHAN_W:1];
        rad_next = rdga_pkg::RAD_W'({s_val, 4'b0000}) + rdga_pkg::RAD_W'({s_val, 3'b000});
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            rad_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg  <= in_valid;
            rad_valid_reg <= sq_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rg_reg <= sq_rg_next;
            sq_gb_reg <= sq_gb_next;
            sq_br_reg <= sq_br_next;
            rad_reg   <= rad_next;
        end
    end

    // seed for the first root cell
    always_comb
    begin
        front_valid     = rad_valid_reg;
        front_data.rad  = rad_reg;
        front_data.rem  = '0;
        front_data.root = '0;
    end

endmodule

>>> design/rdga_cell.sv
// one square root cell: takes two radicand bits, decides one root bit
`timescale 1ns / 1ps

module rdga_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             prev_valid,
    input  rdga_pkg::cell_t  prev_data,
    output logic             cell_valid,
    output rdga_pkg::cell_t  cell_data
);

    logic [rdga_pkg::REM_W+1:0] rem_wide;
    logic [rdga_pkg::REM_W+1:0] trial;
    logic [rdga_pkg::REM_W+1:0] rem_diff;
    logic                       take;
    logic                       valid_reg;
    rdga_pkg::cell_t            data_reg;
    rdga_pkg::cell_t            data_next;

    // bring in the next two radicand bits and test root bit against 4q+1
    always_comb
    begin
        rem_wide = {prev_data.rem, prev_data.rad[rdga_pkg::RAD_W-1 -: 2]};
        trial    = (rdga_pkg::REM_W+2)'({prev_data.root, 2'b01});
        rem_diff = rem_wide - trial;
        take     = (rem_wide >= trial);
        data_next.rad  = {prev_data.rad[rdga_pkg::RAD_W-3:0], 2'b00};
        data_next.rem  = take ? rem_diff[rdga_pkg::REM_W-1:0]
                              : rem_wide[rdga_pkg::REM_W-1:0];
        data_next.root = {prev_data.root[rdga_pkg::ROOT_W-2:0], take};
    end

    // cell valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_data  = data_reg;

endmodule

>>> design/rgb_distance_to_gray_axis.sv
// top level: rgb pixel distance to the gray axis, one pixel per clock unless held
`timescale 1ns / 1ps

//  channel   handshake            payload
//  input     in_valid / in_ready  red, green, blue (8 bits each)
//  output    out_valid / out_ready gray_distance (8 bits)
//
// a pixel may enter every clock while the row advances; each result passes through
// two front stages, eleven root cells (one root bit each) and the output register.
// the whole row advances together; it holds only while the output register is
// full and out_ready is low, so in_ready follows that condition.
// rst_n clears every stage valid bit at once.

module rgb_distance_to_gray_axis
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rdga_pkg::CHAN_W-1:0]   red,
    input  logic [rdga_pkg::CHAN_W-1:0]   green,
    input  logic [rdga_pkg::CHAN_W-1:0]   blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rdga_pkg::DIST_W-1:0]   gray_distance
);

    logic                       adv;
    logic                       chain_valid [0:rdga_pkg::NUM_CELLS];
    rdga_pkg::cell_t            chain_data  [0:rdga_pkg::NUM_CELLS];
    logic [rdga_pkg::ROOT_W-1:0] root_biased;
    logic [rdga_pkg::ROOT_W+15:0] quot_prod;
    logic [rdga_pkg::DIST_W-1:0] dist_next;
    logic [rdga_pkg::DIST_W-1:0] dist_reg;
    logic                       out_valid_reg;

    // row moves whenever the output register is free or being drained
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // differences, squares and radicand
    rdga_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .front_valid (chain_valid[0]),
        .front_data  (chain_data[0])
    );

    // row of root cells, most significant root bit first
    for (genvar i = 0; i < rdga_pkg::NUM_CELLS; i++)
    begin : g_cell
        rdga_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (chain_valid[i]),
            .prev_data  (chain_data[i]),
            .cell_valid (chain_valid[i+1]),
            .cell_data  (chain_data[i+1])
        );
    end

    // rounding: floor((m + 3) / 6) through a reciprocal multiply
    always_comb
    begin
        root_biased = chain_data[rdga_pkg::NUM_CELLS].root + rdga_pkg::ROUND_BIAS;
        quot_prod   = (rdga_pkg::ROOT_W+16)'(root_biased)
                    * (rdga_pkg::ROOT_W+16)'(rdga_pkg::RECIP_SIX);
        dist_next   = quot_prod[rdga_pkg::RECIP_SH +: rdga_pkg::DIST_W];
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[rdga_pkg::NUM_CELLS];
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= dist_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign gray_distance = dist_reg;

endmodule

>>> verif/tb_rgb_distance_to_gray_axis.sv
// testbench for the gray axis distance pipeline: random pixels checked against an integer model
`timescale 1ns / 1ps

module tb_rgb_distance_to_gray_axis;

    localparam int CW = rdga_pkg::CHAN_W;
    localparam int DW = rdga_pkg::DIST_W;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD = 60;
    localparam int END_WAIT = 30;

    typedef struct {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
    } pixel_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [CW-1:0] red = '0;
    logic [CW-1:0] green = '0;
    logic [CW-1:0] blue = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [DW-1:0] gray_distance;

    pixel_t        pixel_q[$];
    logic [DW-1:0] dist_q[$];
    pixel_t        next_pix;
    pixel_t        seen_pix;
    logic          pix_taken = 1'b0;
    int            send_gap = 0;
    int            recv_stall = 0;
    bit            send_idle = 1'b0;
    bit            recv_idle = 1'b0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            pushed_cnt = 0;
    int            accepted_cnt = 0;
    int            quiet_cycles = 0;
    int            fail_count = 0;

    rgb_distance_to_gray_axis uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gray_distance (gray_distance)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // truncating square root, one root bit per pass from the top
    function automatic int floor_sqrt(input int v);
        int root;
        int trial;
        root = 0;
        for (int k = 10; k >= 0; k--)
        begin
            trial = root | (1 << k);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // rounded distance from the gray axis: floor((isqrt(24*s) + 3) / 6)
    function automatic logic [DW-1:0] axis_distance(input pixel_t p);
        int a;
        int b;
        int c;
        int s;
        int m;
        a = p.red;
        b = p.green;
        c = p.blue;
        s = a * a + b * b + c * c - a * b - b * c - c * a;
        m = floor_sqrt(24 * s);
        return DW'((m + 3) / 6);
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // random pixel: uniform, near gray, or channels pinned at the rails
    function automatic pixel_t random_pixel();
        pixel_t p;
        int base;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            p.red = CW'($urandom);
            p.green = CW'($urandom);
            p.blue = CW'($urandom);
        end
        else if (kind < 8)
        begin
            base = $urandom_range(0, 255);
            p.red = CW'(base);
            p.green = CW'((base + $urandom_range(0, 6)) % 256);
            p.blue = CW'((base + 256 - $urandom_range(0, 6)) % 256);
        end
        else
        begin
            p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : CW'($urandom);
            p.blue = $urandom_range(0, 1) ? 8'h00 : CW'($urandom);
        end
        return p;
    endfunction

    task automatic push_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
                              input logic [CW-1:0] b);
        pixel_t p;
        p.red = r;
        p.green = g;
        p.blue = b;
        pixel_q.push_back(p);
        pushed_cnt++;
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(random_pixel());
        pushed_cnt += count;
    endtask

    // every queued pixel transferred and every result back
    task automatic wait_drained();
        while (accepted_cnt != pushed_cnt || dist_q.size() != 0)
            @(negedge clk);
    endtask

    // sender: holds the payload until the transfer, then an optional gap
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !pix_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pixel_q.size() != 0)
            begin
                next_pix = pixel_q.pop_front();
                in_valid <= 1'b1;
                red <= next_pix.red;
                green <= next_pix.green;
                blue <= next_pix.blue;
                send_gap <= send_idle ? pick_gap() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_served + 1;
                recv_stall <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready <= 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 3) == 0)
            begin
                recv_stall <= pick_gap();
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pix_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                seen_pix.red = red;
                seen_pix.green = green;
                seen_pix.blue = blue;
                dist_q.push_back(axis_distance(seen_pix));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (out_valid && out_ready)
            begin
                if (dist_q.size() == 0)
                begin
                    $error("gray_distance: unexpected result %0d", gray_distance);
                    fail_count++;
                end
                else if (dist_q[0] !== gray_distance)
                begin
                    $error("gray_distance mismatch: expected %0d, actual %0d",
                           dist_q[0], gray_distance);
                    fail_count++;
                    void'(dist_q.pop_front());
                end
                else
                begin
                    void'(dist_q.pop_front());
                end
            end
            // watchdog on cycles with no transfer at all
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("rgb_distance_to_gray_axis test failed");
                $finish;
            end
        end
    end

    // stimulus phases
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: gray pixels, rails, single channels, bit patterns
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd128, 8'd128, 8'd128);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_pixel(8'd255, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd255);
        push_pixel(8'd1, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd1, 8'd1);
        push_pixel(8'd254, 8'd255, 8'd255);
        push_pixel(8'd170, 8'd85, 8'd0);
        push_pixel(8'd85, 8'd170, 8'd255);
        push_pixel(8'hAA, 8'h55, 8'hAA);
        push_pixel(8'h55, 8'hAA, 8'h55);
        push_pixel(8'd1, 8'd2, 8'd4);
        push_pixel(8'd128, 8'd64, 8'd32);
        push_pixel(8'd255, 8'd128, 8'd0);
        push_pixel(8'd0, 8'd128, 8'd255);
        wait_drained();

        // back to back with no idling on either side
        send_idle = 1'b0;
        recv_idle = 1'b0;
        push_random(300);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_requests = hold_requests + 1;
        push_random(200);
        wait_drained();

        // random idling on both sides, settings varied per phase
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle = ph[0];
            recv_idle = ph[1] | ph[2];
            if (ph == 5)
                hold_requests = hold_requests + 1;
            push_random(140);
            wait_drained();
        end

        repeat (END_WAIT) @(negedge clk);
        if (fail_count == 0)
            $display("rgb_distance_to_gray_axis test passed");
        else
            $display("rgb_distance_to_gray_axis test failed");
        $finish;
    end

endmodule
